FILE: sv/ia32t_pkg.sv
// Shared types and constants for the 32-bit ALU with fault codes.
`default_nettype none
package ia32t_pkg;

    localparam int unsigned XLEN = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
        OP_REM = 4'd4,  OP_AND = 4'd5,  OP_OR  = 4'd6,  OP_XOR = 4'd7,
        OP_SHL = 4'd8,  OP_SHR = 4'd9,  OP_EQ  = 4'd10, OP_NE  = 4'd11,
        OP_LT  = 4'd12, OP_GE  = 4'd13, OP_GT  = 4'd14, OP_LE  = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_DIVZ   = 2'd1,
        FLT_OVFL   = 2'd2,
        FLT_UNUSED = 2'd3
    } t_fault;

    localparam logic [XLEN-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [4:0]      SHAMT_MASK = 5'h1f;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] operand_x;
        logic signed [31:0] operand_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic               branch_taken;
        logic [1:0]         fault;
    } t_rsp;

    // State carried by one divider cell to the next.
    typedef struct packed {
        logic              vld;
        logic [XLEN-1:0]   rem;     // partial remainder (magnitude)
        logic [XLEN-1:0]   quo;     // dividend bits shifting out, quotient in
        logic [XLEN-1:0]   dvs;     // divisor magnitude
        logic              neg_q;
        logic              neg_r;
        logic              is_div;
        logic [1:0]        fault;
        logic [31:0]       value;   // bypassed result for non-divide ops
        logic              taken;
        logic              use_div;
    } t_cell;

endpackage
`default_nettype wire

FILE: sv/ia32t_cell.sv
// One restoring-division step cell; also carries bypassed results along the row.
`default_nettype none
module ia32t_cell
    import ia32t_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire t_cell i_c,
    output t_cell      o_c
);
    t_cell r_c;
    t_cell n_c;
    logic [XLEN:0] w_trial;
    logic [XLEN:0] w_diff;

    always_comb begin
        n_c = i_c;
        w_trial = {i_c.rem, i_c.quo[XLEN-1]};
        w_diff = w_trial - {1'b0, i_c.dvs};
        n_c.quo = {i_c.quo[XLEN-2:0], ~w_diff[XLEN]};
        n_c.rem = w_diff[XLEN] ? w_trial[XLEN-1:0] : w_diff[XLEN-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_adv) begin
            r_c.vld <= n_c.vld;
        end
        if (i_adv) begin
            r_c.rem <= n_c.rem;     r_c.quo <= n_c.quo;
            r_c.dvs <= n_c.dvs;     r_c.neg_q <= n_c.neg_q;
            r_c.neg_r <= n_c.neg_r; r_c.is_div <= n_c.is_div;
            r_c.fault <= n_c.fault; r_c.value <= n_c.value;
            r_c.taken <= n_c.taken; r_c.use_div <= n_c.use_div;
        end
    end

    assign o_c = r_c;
endmodule
`default_nettype wire

FILE: sv/ia32t_front.sv
// Input stage: decodes the beat, computes simple ops and the product, loads the row.
`default_nettype none
module ia32t_front
    import ia32t_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_vld,
    input  wire t_req i_req,
    output t_cell     o_c
);
    t_cell r_c;
    t_cell n_c;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [4:0]  w_sh;
    logic [63:0] w_prod;
    logic        w_eq;
    logic        w_lt;
    t_op         w_op;

    always_comb begin
        w_x = i_req.operand_x;
        w_y = i_req.operand_y;
        w_op = t_op'(i_req.req_type);
        w_sh = w_y[4:0] & SHAMT_MASK;
        w_prod = w_x * w_y;
        w_eq = (w_x == w_y);
        w_lt = ($signed(w_x) < $signed(w_y));
        n_c = '0;
        n_c.vld = i_vld;
        n_c.dvs = w_y[31] ? (~w_y + 32'd1) : w_y;
        n_c.quo = w_x[31] ? (~w_x + 32'd1) : w_x;
        n_c.neg_q = w_x[31] ^ w_y[31];
        n_c.neg_r = w_x[31];
        n_c.is_div = (w_op == OP_DIV);
        unique case (w_op)
            OP_ADD: n_c.value = w_x + w_y;
            OP_SUB: n_c.value = w_x - w_y;
            OP_MUL: n_c.value = w_prod[31:0];
            OP_DIV, OP_REM: begin
                if (w_y == '0) begin
                    n_c.fault = FLT_DIVZ;
                end else if (w_x == INT_MIN && w_y == '1) begin
                    n_c.fault = FLT_OVFL;
                end else begin
                    n_c.use_div = 1'b1;
                end
            end
            OP_AND: n_c.value = w_x & w_y;
            OP_OR:  n_c.value = w_x | w_y;
            OP_XOR: n_c.value = w_x ^ w_y;
            OP_SHL: n_c.value = w_x << w_sh;
            OP_SHR: n_c.value = $signed(w_x) >>> w_sh;
            OP_EQ:  n_c.taken = w_eq;
            OP_NE:  n_c.taken = !w_eq;
            OP_LT:  n_c.taken = w_lt;
            OP_GE:  n_c.taken = !w_lt;
            OP_GT:  n_c.taken = !w_lt && !w_eq;
            OP_LE:  n_c.taken = w_lt || w_eq;
            default: n_c.value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_adv) begin
            r_c.vld <= n_c.vld;
        end
        if (i_adv) begin
            r_c.rem <= n_c.rem;     r_c.quo <= n_c.quo;
            r_c.dvs <= n_c.dvs;     r_c.neg_q <= n_c.neg_q;
            r_c.neg_r <= n_c.neg_r; r_c.is_div <= n_c.is_div;
            r_c.fault <= n_c.fault; r_c.value <= n_c.value;
            r_c.taken <= n_c.taken; r_c.use_div <= n_c.use_div;
        end
    end

    assign o_c = r_c;
endmodule
`default_nettype wire

FILE: sv/int32_alu_with_traps.sv
// Top level: 32-bit ALU with a row of divider cells and fault reporting.
//
// Usage:
//   Request channel i_req_valid/o_req_stall carries {req_type, operand_x,
//   operand_y}; response channel o_rsp_valid/i_rsp_stall carries {value,
//   branch_taken, fault}. A beat moves when valid is high and stall is low.
//   Every operation, including multiply, runs through the same pipeline:
//   one decode/execute stage, 32 divider cells (one quotient bit each) and
//   an output register, so results leave in request order. Throughput is
//   one beat per cycle while the row is not held.
//   Divide by zero returns value 0 with fault 1; minimum integer by -1
//   returns value 0 with fault 2. Comparisons return value 0 and set
//   branch_taken.
//   When the receiver stalls while the output register is full, the whole
//   row holds and o_req_stall follows i_rsp_stall. Reset (synchronous,
//   active low) empties the row; nothing else is held.
`default_nettype none
module int32_alu_with_traps
    import ia32t_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);
    t_cell w_row [0:XLEN];
    logic  w_adv;
    t_rsp  r_rsp;
    t_rsp  n_rsp;
    logic  r_vld;
    t_cell w_last;
    logic [31:0] w_q;
    logic [31:0] w_r;

    assign w_adv = !(r_vld && i_rsp_stall);
    assign o_req_stall = !w_adv;

    ia32t_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_vld(i_req_valid), .i_req(i_req), .o_c(w_row[0])
    );

    for (genvar g = 0; g < XLEN; g++) begin : g_cell
        ia32t_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
            .i_c(w_row[g]), .o_c(w_row[g+1])
        );
    end

    always_comb begin
        w_last = w_row[XLEN];
        w_q = w_last.neg_q ? (~w_last.quo + 32'd1) : w_last.quo;
        w_r = w_last.neg_r ? (~w_last.rem + 32'd1) : w_last.rem;
        n_rsp.value = w_last.use_div ? (w_last.is_div ? w_q : w_r) : w_last.value;
        n_rsp.branch_taken = w_last.taken;
        n_rsp.fault = w_last.fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= w_last.vld;
        end
        if (w_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_vld;
    assign o_rsp = r_rsp;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> (o_rsp_valid && i_rsp_stall))
        else $error("request stalled while output free");
    a_fault_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.fault != FLT_NONE) |-> (o_rsp.value == '0 && !o_rsp.branch_taken))
        else $error("faulting result not cleared");
    a_fault_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.fault != FLT_UNUSED))
        else $error("unused fault code");
`endif
endmodule
`default_nettype wire
